// ===== src/lsc_pkg.sv =====
// shared types and fixed-point constants for the lookahead soft clipper
// no dependencies
package lsc_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int SPACING_W = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SPACING_W-1:0]       spacing_t;

  // q4.20 constants
  localparam sample_t Q_LIMIT  = 24'sd4194304;
  localparam sample_t Q_THRESH = 24'sd1001382;
  localparam sample_t Q_BASE   = 24'sd740107;
  localparam sample_t Q_SOFT   = 24'sd273589;
  localparam sample_t Q_EASE   = 24'sd261275;
  localparam sample_t Q_HARD   = 24'sd774987;
  localparam sample_t S24_MAX  = 24'sh7fffff;
  localparam sample_t S24_MIN  = 24'sh800000;

  // operands for one multiply-add pass of the shared unit
  typedef struct packed {
    sample_t a;
    sample_t coef;
    sample_t off;
  } mac_op_t;

endpackage

// ===== src/lookahead_soft_clipper_unit.sv =====
// lookahead soft clipper: one word in, one word out
// four dependent multiply-adds run one after another on the shared lsc_mac unit,
// each as a multiply state and an add state, between an accept and a commit state;
// no new word is taken until the result is registered, and a stalled output holds the commit.
// the output lags the input by 'spacing' words (0 taken as 1, capped at MAX_SPACING) through the delay line.
// synchronous reset clears flags, held value, delay line and sets spacing to 1
module lookahead_soft_clipper_unit
  import lsc_pkg::*;
#(
  parameter int MAX_SPACING = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     spacing_we,
  input  spacing_t spacing_wdata,
  input  logic     in_valid,
  output logic     in_stall,
  input  sample_t  sample_in,
  output logic     out_valid,
  input  logic     out_stall,
  output sample_t  sample_out
);

  localparam int LW = $clog2(MAX_SPACING + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PA_MUL = 4'd1;
  localparam logic [3:0] S_PA_ADD = 4'd2;
  localparam logic [3:0] S_PB_MUL = 4'd3;
  localparam logic [3:0] S_PB_ADD = 4'd4;
  localparam logic [3:0] S_NA_MUL = 4'd5;
  localparam logic [3:0] S_NA_ADD = 4'd6;
  localparam logic [3:0] S_NB_MUL = 4'd7;
  localparam logic [3:0] S_NB_ADD = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]  state;
  spacing_t    spacing;
  sample_t     held_value;
  logic        pos_clipped;
  logic        neg_clipped;
  sample_t     delay_store [MAX_SPACING+1];
  sample_t     x_work;
  sample_t     held_work;
  sample_t     x_clamped;
  logic [LW-1:0] len;
  logic        mac_load;
  mac_op_t     mac_op;
  sample_t     mac_result;
  logic        out_free;
  logic        commit;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_DONE) && out_free;

  always_comb begin
    if (sample_in > Q_LIMIT) begin
      x_clamped = Q_LIMIT;
    end else if (sample_in < -Q_LIMIT) begin
      x_clamped = -Q_LIMIT;
    end else begin
      x_clamped = sample_in;
    end
  end

  always_comb begin
    if (spacing == '0) begin
      len = LW'(1);
    end else if (32'(spacing) > MAX_SPACING) begin
      len = LW'(MAX_SPACING);
    end else begin
      len = LW'(spacing);
    end
  end

  always_comb begin
    mac_load = 1'b0;
    mac_op   = '{a: held_work, coef: Q_SOFT, off: Q_BASE};
    unique case (state)
      S_PA_MUL: begin
        mac_load = 1'b1;
        if (x_work < held_work) begin
          mac_op = '{a: x_work, coef: Q_SOFT, off: Q_BASE};
        end else begin
          mac_op = '{a: held_work, coef: Q_HARD, off: Q_EASE};
        end
      end
      S_PB_MUL: begin
        mac_load = 1'b1;
        mac_op   = '{a: held_work, coef: Q_SOFT, off: Q_BASE};
      end
      S_NA_MUL: begin
        mac_load = 1'b1;
        if (x_work > held_work) begin
          mac_op = '{a: x_work, coef: Q_SOFT, off: -Q_BASE};
        end else begin
          mac_op = '{a: held_work, coef: Q_HARD, off: -Q_EASE};
        end
      end
      S_NB_MUL: begin
        mac_load = 1'b1;
        mac_op   = '{a: held_work, coef: Q_SOFT, off: -Q_BASE};
      end
      default: begin
        mac_load = 1'b0;
      end
    endcase
  end

  lsc_mac u_mac (
    .clk    (clk),
    .load   (mac_load),
    .op     (mac_op),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_W'(1);
    end else if (spacing_we) begin
      spacing <= spacing_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held_value  <= '0;
      pos_clipped <= 1'b0;
      neg_clipped <= 1'b0;
      for (int i = 0; i <= MAX_SPACING; i++) begin
        delay_store[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_work    <= x_clamped;
            held_work <= held_value;
            state     <= S_PA_MUL;
          end
        end
        S_PA_MUL: state <= S_PA_ADD;
        S_PA_ADD: begin
          if (pos_clipped) begin
            held_work <= mac_result;
          end
          state <= S_PB_MUL;
        end
        S_PB_MUL: state <= S_PB_ADD;
        S_PB_ADD: begin
          pos_clipped <= (x_work > Q_THRESH);
          if (x_work > Q_THRESH) begin
            x_work <= mac_result;
          end
          state <= S_NA_MUL;
        end
        S_NA_MUL: state <= S_NA_ADD;
        S_NA_ADD: begin
          if (neg_clipped) begin
            held_work <= mac_result;
          end
          state <= S_NB_MUL;
        end
        S_NB_MUL: state <= S_NB_ADD;
        S_NB_ADD: begin
          neg_clipped <= (x_work < -Q_THRESH);
          if (x_work < -Q_THRESH) begin
            x_work <= mac_result;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (commit) begin
            sample_out <= held_work;
            // delay line: new word enters at len-1 and len, entries below shift down
            for (int i = 0; i < MAX_SPACING; i++) begin
              if (LW'(i) < len) begin
                if (LW'(i + 1) == len) begin
                  delay_store[i] <= x_work;
                end else begin
                  delay_store[i] <= delay_store[i+1];
                end
              end else if (LW'(i) == len) begin
                delay_store[i] <= x_work;
              end
            end
            if (len == LW'(MAX_SPACING)) begin
              delay_store[MAX_SPACING] <= x_work;
            end
            if (len == LW'(1)) begin
              held_value <= x_work;
            end else begin
              held_value <= delay_store[1];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_PA_MUL))
    else $error("accepted word did not start the sequence");

  a_limit_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_PA_MUL) |-> (x_work <= Q_LIMIT && x_work >= -Q_LIMIT))
    else $error("loaded sample outside hard limit");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (len >= LW'(1) && len <= LW'(MAX_SPACING)))
    else $error("delay length out of range");

  a_commit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE && out_valid))
    else $error("result committed over a waiting word");

endmodule

// ===== src/lsc_mac.sv =====
// shared multiply-add unit: registered 24x24 product, then round, offset, saturate
// depends on lsc_pkg
module lsc_mac
  import lsc_pkg::*;
(
  input  logic    clk,
  input  logic    load,
  input  mac_op_t op,
  output sample_t result
);

  logic signed [47:0] prod;
  sample_t            off;
  logic signed [47:0] rounded;
  logic signed [27:0] scaled;
  logic signed [28:0] total;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 48'(op.a) * 48'(op.coef);
      off  <= op.off;
    end
  end

  always_comb begin
    rounded = prod + 48'sd524288;
    scaled  = 28'(rounded >>> 20);
    total   = 29'(scaled) + 29'(off);
    if (total > 29'(S24_MAX)) begin
      result = S24_MAX;
    end else if (total < 29'(S24_MIN)) begin
      result = S24_MIN;
    end else begin
      result = SAMPLE_W'(total);
    end
  end

endmodule
